/* rtl/icc_profile_structure_check_unit_macros.svh */
// Assertion macros for the ICC profile structure checker.
// Used by icc_psc_checker; needs nothing else.
`ifndef ICC_PROFILE_STRUCTURE_CHECK_UNIT_MACROS_SVH
`define ICC_PROFILE_STRUCTURE_CHECK_UNIT_MACROS_SVH

// Generic clocked assertion with an active-low reset.
`define ICC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset names.
`define ICC_ASSERT_STD(lbl, prop, msg) \
  `ICC_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

/* rtl/icc_psc_pkg.sv */
// Shared types and constants of the ICC profile structure checker.
// No dependencies.
package icc_psc_pkg;

  localparam int unsigned MaxTagsDefault = 4096;

  // Header layout (byte positions in the profile)
  localparam logic [31:0] SizeEndPos   = 32'd3;
  localparam logic [31:0] RgbFirstPos  = 32'd16;
  localparam logic [31:0] RgbLastPos   = 32'd19;
  localparam logic [31:0] AcspFirstPos = 32'd36;
  localparam logic [31:0] AcspLastPos  = 32'd39;
  localparam logic [31:0] CountEndPos  = 32'd131;
  localparam logic [31:0] TagTablePos  = 32'd132;
  localparam logic [31:0] PosMax       = 32'hFFFF_FFFF;

  // Tag entry: 12 bytes, offset ends at byte 7, length at byte 11
  localparam int unsigned TagEntryBytes = 12;
  localparam logic [3:0]  PhaseOffsEnd  = 4'd7;
  localparam logic [3:0]  PhaseEntryEnd = 4'd11;

  localparam logic [31:0] SigRgb  = 32'h5247_4220; // "RGB "
  localparam logic [31:0] SigAcsp = 32'h6163_7370; // "acsp"

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } item_t;

  // Byte i (0 = first in file order) of a big-endian signature
  function automatic logic [7:0] sig_byte(logic [31:0] sig, logic [1:0] i);
    logic [7:0] b;
    case (i)
      2'd0:    b = sig[31:24];
      2'd1:    b = sig[23:16];
      2'd2:    b = sig[15:8];
      default: b = sig[7:0];
    endcase
    return b;
  endfunction

endpackage

/* rtl/icc_psc_core.sv */
// Per-profile state and structure checks, one byte per fired item.
// Depends on icc_psc_pkg.
module icc_psc_core import icc_psc_pkg::*; #(
  parameter int unsigned MaxTags = MaxTagsDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i,
  output logic  verdict_o
);

  localparam int unsigned TW = $clog2(MaxTags + 1);
  localparam int unsigned NW = TW + 5;

  logic          req_rgb_q;
  logic [31:0]   pos_q, pos_d;
  logic [31:0]   word_q, word_d;
  logic [31:0]   word_in;
  logic [31:0]   decl_q, decl_d;
  logic [TW-1:0] tags_q, tags_d;
  logic [TW-1:0] idx_q, idx_d;
  logic [3:0]    phase_q, phase_d;
  logic [31:0]   offs_q, offs_d;
  logic          fail_q, fail_d;
  logic          rgb_mis_q, rgb_mis_d;
  logic [NW-1:0] table_end;

  // word including the current byte, before any end-of-profile clearing
  assign word_in   = {word_q[23:0], item_i.data};
  assign table_end = NW'(TagTablePos) + NW'(word_in[TW-1:0]) * NW'(TagEntryBytes);

  always_comb begin
    word_d    = word_in;
    pos_d     = pos_q;
    decl_d    = decl_q;
    tags_d    = tags_q;
    idx_d     = idx_q;
    phase_d   = phase_q;
    offs_d    = offs_q;
    fail_d    = fail_q;
    rgb_mis_d = rgb_mis_q;
    verdict_o = 1'b0;

    if (pos_q == SizeEndPos) begin
      decl_d = word_in;
    end

    if (pos_q >= RgbFirstPos && pos_q <= RgbLastPos) begin
      if (item_i.data != sig_byte(SigRgb, pos_q[1:0])) begin
        rgb_mis_d = 1'b1;
      end
      if (pos_q == RgbLastPos && req_rgb_q && rgb_mis_d) begin
        fail_d = 1'b1;
      end
    end

    if (pos_q >= AcspFirstPos && pos_q <= AcspLastPos &&
        item_i.data != sig_byte(SigAcsp, pos_q[1:0])) begin
      fail_d = 1'b1;
    end

    if (pos_q == CountEndPos) begin
      idx_d   = '0;
      phase_d = '0;
      if (word_in > 32'(MaxTags)) begin
        fail_d = 1'b1;
        tags_d = '0;
      end else begin
        tags_d = word_in[TW-1:0];
        if ({{(33-NW){1'b0}}, table_end} > {1'b0, decl_q}) begin
          fail_d = 1'b1;
        end
      end
    end

    // tag entries: phase counts bytes within the current 12-byte entry
    if (pos_q >= TagTablePos && idx_q < tags_q) begin
      if (phase_q == PhaseOffsEnd) begin
        offs_d = word_in;
        if (word_in > decl_q) fail_d = 1'b1;
      end
      if (phase_q == PhaseEntryEnd) begin
        if (offs_q > decl_q || word_in > decl_q - offs_q) fail_d = 1'b1;
        phase_d = '0;
        idx_d   = idx_q + TW'(1);
      end else begin
        phase_d = phase_q + 4'd1;
      end
    end

    if (item_i.last) begin
      verdict_o = !fail_d && pos_q >= CountEndPos &&
                  ({1'b0, pos_q} + 33'd1 == {1'b0, decl_q});
      pos_d     = '0;
      word_d    = '0;
      decl_d    = '0;
      tags_d    = '0;
      idx_d     = '0;
      phase_d   = '0;
      offs_d    = '0;
      fail_d    = 1'b0;
      rgb_mis_d = 1'b0;
    end else if (pos_q == PosMax) begin
      fail_d = 1'b1;
    end else begin
      pos_d = pos_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_rgb_q <= 1'b1;
    end else if (cfg_we_i) begin
      req_rgb_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      word_q    <= '0;
      decl_q    <= '0;
      tags_q    <= '0;
      idx_q     <= '0;
      phase_q   <= '0;
      offs_q    <= '0;
      fail_q    <= 1'b0;
      rgb_mis_q <= 1'b0;
    end else if (fire_i) begin
      pos_q     <= pos_d;
      word_q    <= word_d;
      decl_q    <= decl_d;
      tags_q    <= tags_d;
      idx_q     <= idx_d;
      phase_q   <= phase_d;
      offs_q    <= offs_d;
      fail_q    <= fail_d;
      rgb_mis_q <= rgb_mis_d;
    end
  end

endmodule

/* rtl/icc_psc_out_reg.sv */
// Result register on the master side; frees itself when the item is taken.
// Depends on icc_psc_pkg only for house consistency of imports.
module icc_psc_out_reg import icc_psc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic verdict_i,
  input  logic tready_i,
  output logic tvalid_o,
  output logic verdict_o,
  output logic free_o
);

  logic valid_q, valid_d;
  logic verdict_q;

  assign free_o    = !valid_q || tready_i;
  assign tvalid_o  = valid_q;
  assign verdict_o = verdict_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      verdict_q <= verdict_i;
    end
  end

endmodule

/* rtl/icc_profile_structure_check_unit.sv */
// ICC profile structure checker: one profile byte per item, verdict on tlast.
// Throughput: one byte per cycle; only a verdict waiting at a stalled master
// side holds up the next last byte. The verdict reaches the master side through
// the input register, the checks and the result register.
// Reset (async, active low) clears all profile state; require_rgb resets to 1.
module icc_profile_structure_check_unit import icc_psc_pkg::*; #(
  parameter int unsigned MaxTags = MaxTagsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] profile_byte
  input  logic       s_axis_tlast,  // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [0] profile_valid, [7:1] zero
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i    // require_rgb
);

  logic  in_valid_q;
  item_t in_item_q;
  logic  advance;
  logic  out_free;
  logic  verdict;
  logic  out_verdict;

  assign advance       = in_valid_q && (!in_item_q.last || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= '{last: s_axis_tlast, data: s_axis_tdata};
    end
  end

  icc_psc_core #(
    .MaxTags(MaxTags)
  ) u_core (
    .clk_i,
    .rst_ni,
    .fire_i     (advance),
    .item_i     (in_item_q),
    .cfg_we_i,
    .cfg_wdata_i,
    .verdict_o  (verdict)
  );

  icc_psc_out_reg u_out (
    .clk_i,
    .rst_ni,
    .load_i    (advance && in_item_q.last),
    .verdict_i (verdict),
    .tready_i  (m_axis_tready),
    .tvalid_o  (m_axis_tvalid),
    .verdict_o (out_verdict),
    .free_o    (out_free)
  );

  assign m_axis_tdata = {7'b0, out_verdict};

endmodule

/* rtl/icc_psc_checker.sv */
// Port-level checker for the ICC profile structure checker, bound to the top.
// Depends on icc_profile_structure_check_unit_macros.svh.
`include "icc_profile_structure_check_unit_macros.svh"

module icc_psc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic out_wait;

  assign out_wait = m_axis_tvalid && !m_axis_tready;

  // a verdict is one bit; the rest of the byte is padding
  `ICC_ASSERT_STD(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[7:1] == 7'b0, "verdict padding set")

  `ICC_ASSERT_STD(a_out_hold, out_wait |=> m_axis_tvalid && $stable(m_axis_tdata), "verdict moved")

  // input side stalls only behind a verdict the master side has not taken
  `ICC_ASSERT_STD(a_stall_cause, !s_axis_tready |-> out_wait, "input stalled without backpressure")

  // a stall needs a held item, i.e. a prior stall or a prior accept
  `ICC_ASSERT_STD(a_stall_held, !s_axis_tready |-> $past(!s_axis_tready || s_axis_tvalid), "no held item")

endmodule

bind icc_profile_structure_check_unit icc_psc_checker u_checker (.*);

/* tb/icc_verdict_monitor.sv */
// Verdict monitor for the ICC profile structure checker: tracks every accepted byte,
// predicts the per-profile verdict and compares it with the master-side items.
// Depends on icc_psc_pkg for the header layout and signature constants.
module icc_verdict_monitor import icc_psc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned compared_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        rgb_required;
  logic [31:0] next_pos;
  logic [31:0] word_window;
  logic [31:0] size_field;
  logic [31:0] entry_offset;
  logic [12:0] tag_count;
  logic        header_failed;
  logic        rgb_bad;
  logic        verdict_q[$];
  logic        want;

  task automatic clear_profile_state();
    next_pos      = '0;
    word_window   = '0;
    size_field    = '0;
    entry_offset  = '0;
    tag_count     = '0;
    header_failed = 1'b0;
    rgb_bad       = 1'b0;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    logic [31:0] p;
    logic [31:0] rel;
    logic [31:0] slot;
    logic [63:0] len;
    int          k;
    p = next_pos;
    word_window = {word_window[23:0], b};

    if (p == SizeEndPos) size_field = word_window;

    if (p >= RgbFirstPos && p <= RgbLastPos) begin
      k = p - RgbFirstPos;
      if (b != SigRgb[8*(3-k) +: 8]) rgb_bad = 1'b1;
      // colour space requirement is decided on the last signature byte
      if (p == RgbLastPos && rgb_required && rgb_bad) header_failed = 1'b1;
    end

    if (p >= AcspFirstPos && p <= AcspLastPos) begin
      k = p - AcspFirstPos;
      if (b != SigAcsp[8*(3-k) +: 8]) header_failed = 1'b1;
    end

    if (p == CountEndPos) begin
      if (word_window > MaxTagsDefault) begin
        header_failed = 1'b1;
        tag_count     = '0;
      end else begin
        tag_count = word_window[12:0];
        if (64'd132 + {32'd0, word_window} * 64'd12 > {32'd0, size_field})
          header_failed = 1'b1;
      end
    end

    if (p >= TagTablePos) begin
      rel  = p - TagTablePos;
      slot = rel % TagEntryBytes;
      if (rel / TagEntryBytes < {19'd0, tag_count}) begin
        if (slot == 32'd7) begin
          entry_offset = word_window;
          if (entry_offset > size_field) header_failed = 1'b1;
        end else if (slot == 32'd11) begin
          if (entry_offset > size_field || word_window > size_field - entry_offset)
            header_failed = 1'b1;
        end
      end
    end

    if (!last) begin
      // saturating position counter; running past it spoils the profile
      if (next_pos == PosMax) header_failed = 1'b1;
      else next_pos = p + 32'd1;
    end else begin
      len = {32'd0, p} + 64'd1;
      verdict_q.push_back(!header_failed && len >= 64'd132 && len == {32'd0, size_field});
      clear_profile_state();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgb_required = 1'b1;
      clear_profile_state();
      verdict_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      compared_o   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $error("profile_valid: no verdict pending, got %0d", m_axis_tdata[0]);
          fail_count_o++;
        end else begin
          want = verdict_q.pop_front();
          compared_o++;
          if (m_axis_tdata[0] !== want) begin
            $error("profile_valid: expected %0d, got %0d", want, m_axis_tdata[0]);
            fail_count_o++;
          end
          if (m_axis_tdata[7:1] !== 7'd0) begin
            $error("tdata pad: expected 0, got %0h", m_axis_tdata[7:1]);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) rgb_required = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata, s_axis_tlast);
      pending_o = verdict_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for icc_profile_structure_check_unit: clock, reset, byte stream
// stimulus, result-side backpressure and the final verdict.
// Depends on icc_psc_pkg, the block itself and icc_verdict_monitor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import icc_psc_pkg::*;

  localparam int unsigned LimitCycles = 800000;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned ItemsTarget = 1550;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'd0;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       cfg_we_i      = 1'b0;
  logic       cfg_wdata_i   = 1'b0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned compared;
  int unsigned cycle_count = 0;
  int unsigned sent_bytes  = 0;
  logic        no_idle      = 1'b0;
  logic        hold_request = 1'b0;
  int          fill_mode    = 0;   // 0 random, 1 all zeros, 2 all ones
  logic [7:0]  image[$];

  icc_profile_structure_check_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  icc_verdict_monitor u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .compared_o    (compared)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LimitCycles) begin
      $error("timeout after %0d cycles, %0d verdicts outstanding", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic set_word(input int pos, input logic [31:0] v);
    for (int k = 0; k < 4; k++) image[pos + k] = v[31 - 8*k -: 8];
  endtask

  // Well-formed profile: header signatures, declared size, tag table inside bounds
  task automatic compose_profile(input int tags, input int extra);
    int total;
    int off;
    total = 132 + 12 * tags + extra;
    image.delete();
    for (int i = 0; i < total; i++)
      image.push_back(fill_mode == 1 ? 8'h00 : fill_mode == 2 ? 8'hFF : 8'($urandom_range(0, 255)));
    set_word(0, total);
    set_word(16, SigRgb);
    set_word(36, SigAcsp);
    set_word(128, tags);
    for (int t = 0; t < tags; t++) begin
      off = $urandom_range(0, total);
      set_word(132 + 12 * t + 4, off);
      set_word(132 + 12 * t + 8, $urandom_range(0, total - off));
    end
  endtask

  task automatic noise_profile(input int len);
    image.delete();
    for (int i = 0; i < len; i++) image.push_back(8'($urandom_range(0, 255)));
  endtask

  // Called at a falling edge; returns at the falling edge after the handshake
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    sent_bytes++;
  endtask

  task automatic send_image();
    for (int i = 0; i < image.size(); i++) send_byte(image[i], i == image.size() - 1);
  endtask

  // Drain: wait until every verdict is back, then let the result pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_rgb(input logic v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Result side: random stalls per item, one long hold-off on request
  initial begin : result_sink
    int stall;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int          total;
    int          tags;
    int          profiles;
    int          kind;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed profiles, colour space required
    write_rgb(1'b1);
    fill_mode = 1;
    compose_profile(0, 0);
    send_image();
    fill_mode = 2;
    compose_profile(2, 10);
    total = image.size();
    set_word(132 + 4, total);       // offset at the very end, zero length
    set_word(132 + 8, 0);
    set_word(144 + 4, 0);           // whole profile as one tag
    set_word(144 + 8, total);
    send_image();
    fill_mode = 0;
    image.delete();
    image.push_back(8'hFF);         // one-byte profile
    send_image();
    compose_profile(0, 0);          // one byte short of the header
    void'(image.pop_back());
    set_word(0, 131);
    send_image();
    compose_profile(0, 0);          // one tag announced, table ends past the last byte
    set_word(128, 1);
    send_image();
    compose_profile(0, 0);          // count at the limit, table cannot fit
    set_word(128, MaxTagsDefault);
    send_image();
    compose_profile(0, 0);
    set_word(128, MaxTagsDefault + 1);
    send_image();
    compose_profile(1, 4);          // length runs past the end
    set_word(132 + 4, 4);
    set_word(132 + 8, image.size() - 3);
    send_image();

    // ---- colour space not required
    write_rgb(1'b0);
    compose_profile(0, 3);
    image[16] = 8'h72;
    send_image();

    // ---- random profiles, mostly well formed
    profiles = 0;
    while (sent_bytes < ItemsTarget) begin
      if (profiles % 2 == 0) write_rgb(1'($urandom_range(0, 1)));
      if (profiles == 1) begin
        // short profiles pile up behind a stalled result side
        no_idle      = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 12; i++) begin
          noise_profile($urandom_range(1, 3));
          send_image();
        end
        profiles += 12;
        continue;
      end
      no_idle = ($urandom_range(0, 4) == 0);
      kind    = $urandom_range(0, 99);
      tags    = $urandom_range(0, 3);
      compose_profile(tags, $urandom_range(0, 24));
      total   = image.size();
      if (kind < 55) begin
        if ($urandom_range(0, 9) < 3)
          image[16 + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
      end else if (kind < 75) begin
        case ($urandom_range(0, 4))
          0: set_word(0, $urandom_range(0, 1) ? total + 1 : total - 1);
          1: image[36 + $urandom_range(0, 3)] = 8'($urandom_range(0, 255));
          2: set_word(128, $urandom_range(0, 1) ? $urandom_range(0, 6)
                                              : MaxTagsDefault + $urandom_range(1, 1000));
          3: begin
            if (tags > 0)
              set_word(136 + 12 * $urandom_range(0, tags - 1) + 4 * $urandom_range(0, 1),
                       $urandom_range(0, 1) ? $urandom() : $urandom_range(0, total + 2));
            else
              set_word(0, $urandom());
          end
          default: image[$urandom_range(0, total - 1)] = 8'($urandom_range(0, 255));
        endcase
      end else if (kind < 90) begin
        noise_profile($urandom_range(1, 140));
      end else if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(1, 4)) void'(image.pop_back());
      end else begin
        repeat ($urandom_range(1, 4)) image.push_back(8'($urandom_range(0, 255)));
      end
      send_image();
      profiles++;
    end

    s_axis_tvalid <= 1'b0;
    no_idle       = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Checked %0d profile verdicts over %0d bytes with require_rgb at 0 and 1,",
             compared, sent_bytes);
    $display("including short, truncated and corrupted profiles and oversized tag counts.");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/icc_psc_pkg.sv
rtl/icc_psc_core.sv
rtl/icc_psc_out_reg.sv
rtl/icc_profile_structure_check_unit.sv
rtl/icc_psc_checker.sv
tb/icc_verdict_monitor.sv
tb/tb_top.sv
